FILE: src/spi_ts_pkg.sv
// Shared types, constants and helpers for the SPI transaction sequencer.
// No dependencies; compiled first.
`default_nettype none

package spi_ts_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_XCHG  = 1'b1;

  localparam int SLOT_W = 17;

  // Classified request as it sits in the queue between front and back
  typedef struct packed {
    logic              req_type;
    logic [15:0]       tx_len;
    logic [15:0]       rx_len;
    logic [SLOT_W-1:0] slots;
    logic              bit_reversed;
    logic              invert_cs;
    logic              skip_cs_assert;
    logic              skip_cs_deassert;
    logic [7:0]        prescale_request;
    logic [15:0]       cs_select;
    logic [7:0]        tx_byte;
    logic [7:0]        miso_byte;
  } cmd_t;

  typedef struct packed {
    logic        mosi_valid;
    logic [7:0]  mosi_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        cs_drive;
    logic        cs_level;
    logic [15:0] cs_line;
    logic [7:0]  clock_prescale;
    logic        done_res;
    logic        idle_error;
    logic        last;
  } res_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/spi_ts_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on nothing; payload widths are fixed.
`default_nettype none

interface spi_ts_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] tx_len;
  logic [15:0] rx_len;
  logic        skip_tx;
  logic        bit_reversed;
  logic        invert_cs;
  logic        skip_cs_assert;
  logic        skip_cs_deassert;
  logic [7:0]  prescale_request;
  logic [15:0] cs_select;
  logic [7:0]  tx_byte;
  logic [7:0]  miso_byte;

  modport source (
    output valid, req_type, tx_len, rx_len, skip_tx, bit_reversed, invert_cs,
           skip_cs_assert, skip_cs_deassert, prescale_request, cs_select,
           tx_byte, miso_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, tx_len, rx_len, skip_tx, bit_reversed, invert_cs,
           skip_cs_assert, skip_cs_deassert, prescale_request, cs_select,
           tx_byte, miso_byte,
    output ready
  );
endinterface

interface spi_ts_rsp_if;
  logic        valid;
  logic        ready;
  logic        mosi_valid;
  logic [7:0]  mosi_byte;
  logic        rx_valid;
  logic [7:0]  rx_byte;
  logic        cs_drive;
  logic        cs_level;
  logic [15:0] cs_line;
  logic [7:0]  clock_prescale;
  logic        done_res;
  logic        idle_error;
  logic        last;

  modport source (
    output valid, mosi_valid, mosi_byte, rx_valid, rx_byte, cs_drive, cs_level,
           cs_line, clock_prescale, done_res, idle_error, last,
    input  ready
  );
  modport sink (
    input  valid, mosi_valid, mosi_byte, rx_valid, rx_byte, cs_drive, cs_level,
           cs_line, clock_prescale, done_res, idle_error, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/spi_transaction_sequencer.sv
// SPI transaction sequencer top level: front end, request queue, sequencer core.
// Throughput: one request per cycle while the result side is ready; a start with zero
// slots yields two results and holds the core until both are produced.
// Reset (synchronous, rst high) empties the queue, drops any transaction and
// clears all held state; no result is pending afterwards.
`default_nettype none

module spi_transaction_sequencer
  import spi_ts_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  spi_ts_req_if.sink   req,
  spi_ts_rsp_if.source rsp
);

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  spi_ts_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  spi_ts_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  spi_ts_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .empty (q_empty),
    .pop   (q_pop),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire

FILE: src/spi_ts_front.sv
// Request front end: accepts requests, works out the slot count, pushes to the queue.
// Depends on spi_ts_pkg and spi_ts_req_if.
`default_nettype none

module spi_ts_front
  import spi_ts_pkg::*;
(
  spi_ts_req_if.sink req,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  logic [SLOT_W-1:0] sum_len;
  logic [SLOT_W-1:0] max_len;

  assign sum_len = {1'b0, req.tx_len} + {1'b0, req.rx_len};
  assign max_len = (req.tx_len >= req.rx_len) ? {1'b0, req.tx_len} : {1'b0, req.rx_len};

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  always_comb begin
    q_data.req_type         = req.req_type;
    q_data.tx_len           = req.tx_len;
    q_data.rx_len           = req.rx_len;
    q_data.slots            = req.skip_tx ? sum_len : max_len;
    q_data.bit_reversed     = req.bit_reversed;
    q_data.invert_cs        = req.invert_cs;
    q_data.skip_cs_assert   = req.skip_cs_assert;
    q_data.skip_cs_deassert = req.skip_cs_deassert;
    q_data.prescale_request = req.prescale_request;
    q_data.cs_select        = req.cs_select;
    q_data.tx_byte          = req.tx_byte;
    q_data.miso_byte        = req.miso_byte;
  end

endmodule

`default_nettype wire

FILE: src/spi_ts_fifo.sv
// Short request queue between front end and sequencer core.
// Depends on spi_ts_pkg.
`default_nettype none

module spi_ts_fifo
  import spi_ts_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/spi_ts_back.sv
// Sequencer core: holds transaction state, executes queued requests, registers results.
// Depends on spi_ts_pkg and spi_ts_rsp_if.
`default_nettype none

module spi_ts_back
  import spi_ts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t head,
  input  logic empty,
  output logic pop,
  spi_ts_rsp_if.source rsp
);

  localparam logic PH_RUN   = 1'b0;
  localparam logic PH_DONE2 = 1'b1;

  logic              phase, phase_next;
  logic              active, active_next;
  logic [SLOT_W-1:0] slots_left, slots_left_next;
  logic [15:0]       tx_left, tx_left_next;
  logic [15:0]       rx_left, rx_left_next;
  logic              held_reverse, held_reverse_next;
  logic              held_invert, held_invert_next;
  logic              held_skip_deassert, held_skip_deassert_next;
  logic [15:0]       held_cs_select, held_cs_select_next;
  logic [7:0]        held_prescale, held_prescale_next;

  logic              out_valid;
  res_t              out_res;
  res_t              res;
  logic              load;
  logic              work;
  logic [SLOT_W-1:0] slots_dec;
  logic [7:0]        tx_sel;
  logic [7:0]        rx_sel;

  assign load      = !out_valid || rsp.ready;
  assign work      = load && !empty;
  assign slots_dec = slots_left - 1'b1;
  assign tx_sel    = held_reverse ? rev8(head.tx_byte) : head.tx_byte;
  assign rx_sel    = held_reverse ? rev8(head.miso_byte) : head.miso_byte;

  always_comb begin
    phase_next              = phase;
    active_next             = active;
    slots_left_next         = slots_left;
    tx_left_next            = tx_left;
    rx_left_next            = rx_left;
    held_reverse_next       = held_reverse;
    held_invert_next        = held_invert;
    held_skip_deassert_next = held_skip_deassert;
    held_cs_select_next     = held_cs_select;
    held_prescale_next      = held_prescale;
    pop                     = 1'b0;
    res                     = '0;
    res.cs_line             = held_cs_select;
    res.clock_prescale      = held_prescale;
    if (work) begin
      if (phase == PH_DONE2) begin
        res.done_res = 1'b1;
        res.cs_drive = !held_skip_deassert;
        res.cs_level = !held_invert && !held_skip_deassert;
        res.last     = 1'b1;
        pop          = 1'b1;
        phase_next   = PH_RUN;
      end else if (head.req_type == REQ_START) begin
        held_reverse_next       = head.bit_reversed;
        held_invert_next        = head.invert_cs;
        held_skip_deassert_next = head.skip_cs_deassert;
        held_cs_select_next     = head.cs_select;
        held_prescale_next      = head.prescale_request;
        tx_left_next            = head.tx_len;
        rx_left_next            = head.rx_len;
        slots_left_next         = head.slots;
        res.cs_line             = head.cs_select;
        res.clock_prescale      = head.prescale_request;
        res.cs_drive            = !head.skip_cs_assert;
        res.cs_level            = head.invert_cs && !head.skip_cs_assert;
        if (head.slots != '0) begin
          active_next = 1'b1;
          res.last    = 1'b1;
          pop         = 1'b1;
        end else begin
          active_next = 1'b0;
          phase_next  = PH_DONE2;
        end
      end else if (!active) begin
        res.idle_error = 1'b1;
        res.last       = 1'b1;
        pop            = 1'b1;
      end else begin
        res.mosi_valid  = 1'b1;
        res.last        = 1'b1;
        pop             = 1'b1;
        slots_left_next = slots_dec;
        if (tx_left != '0) begin
          tx_left_next  = tx_left - 1'b1;
          res.mosi_byte = tx_sel;
        end
        if ((rx_left != '0) && (slots_dec < {1'b0, rx_left})) begin
          rx_left_next = rx_left - 1'b1;
          res.rx_valid = 1'b1;
          res.rx_byte  = rx_sel;
        end
        if (slots_dec == '0) begin
          active_next  = 1'b0;
          res.done_res = 1'b1;
          res.cs_drive = !held_skip_deassert;
          res.cs_level = !held_invert && !held_skip_deassert;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_RUN;
      active             <= 1'b0;
      slots_left         <= '0;
      tx_left            <= '0;
      rx_left            <= '0;
      held_reverse       <= 1'b0;
      held_invert        <= 1'b0;
      held_skip_deassert <= 1'b0;
      held_cs_select     <= '0;
      held_prescale      <= '0;
      out_valid          <= 1'b0;
    end else begin
      phase              <= phase_next;
      active             <= active_next;
      slots_left         <= slots_left_next;
      tx_left            <= tx_left_next;
      rx_left            <= rx_left_next;
      held_reverse       <= held_reverse_next;
      held_invert        <= held_invert_next;
      held_skip_deassert <= held_skip_deassert_next;
      held_cs_select     <= held_cs_select_next;
      held_prescale      <= held_prescale_next;
      if (load) begin
        out_valid <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.mosi_valid     = out_res.mosi_valid;
  assign rsp.mosi_byte      = out_res.mosi_byte;
  assign rsp.rx_valid       = out_res.rx_valid;
  assign rsp.rx_byte        = out_res.rx_byte;
  assign rsp.cs_drive       = out_res.cs_drive;
  assign rsp.cs_level       = out_res.cs_level;
  assign rsp.cs_line        = out_res.cs_line;
  assign rsp.clock_prescale = out_res.clock_prescale;
  assign rsp.done_res       = out_res.done_res;
  assign rsp.idle_error     = out_res.idle_error;
  assign rsp.last           = out_res.last;

endmodule

`default_nettype wire

FILE: src/spi_ts_checker.sv
// Port-level checks for the SPI transaction sequencer, bound to the top level.
// Depends on spi_transaction_sequencer's channel ports.
`default_nettype none

module spi_ts_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  input wire logic ready,
  input wire logic mosi_valid,
  input wire logic rx_valid,
  input wire logic cs_drive,
  input wire logic cs_level,
  input wire logic done_res,
  input wire logic idle_error,
  input wire logic last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result dropped while stalled");

  a_idle_err: assert property (@(posedge clk) disable iff (rst)
    valid && idle_error |-> last && !done_res && !mosi_valid && !cs_drive)
    else $error("idle error result carries transfer data");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    valid && done_res |-> last)
    else $error("done result not marked last");

  a_cs_level: assert property (@(posedge clk) disable iff (rst)
    valid && cs_level |-> cs_drive)
    else $error("chip select level without drive");

  a_rx_slot: assert property (@(posedge clk) disable iff (rst)
    valid && rx_valid |-> mosi_valid && !idle_error)
    else $error("receive byte outside an exchange slot");

endmodule

bind spi_transaction_sequencer spi_ts_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (rsp.valid),
  .ready      (rsp.ready),
  .mosi_valid (rsp.mosi_valid),
  .rx_valid   (rsp.rx_valid),
  .cs_drive   (rsp.cs_drive),
  .cs_level   (rsp.cs_level),
  .done_res   (rsp.done_res),
  .idle_error (rsp.idle_error),
  .last       (rsp.last)
);

`default_nettype wire

FILE: tb/sv/spi_transaction_sequencer_test.sv
// Self-checking test of the SPI transaction sequencer over its request/result channels.
// Depends on spi_ts_pkg, spi_ts_req_if/spi_ts_rsp_if and spi_transaction_sequencer.
`default_nettype none

module spi_transaction_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spi_ts_pkg::*;

  typedef struct {
    logic        req_type;
    logic [15:0] tx_len;
    logic [15:0] rx_len;
    logic        skip_tx;
    logic        bit_reversed;
    logic        invert_cs;
    logic        skip_cs_assert;
    logic        skip_cs_deassert;
    logic [7:0]  prescale_request;
    logic [15:0] cs_select;
    logic [7:0]  tx_byte;
    logic [7:0]  miso_byte;
  } spi_req_t;

  class seq_scoreboard;
    logic        active;
    logic [16:0] slots_left;
    logic [15:0] tx_left;
    logic [15:0] rx_left;
    logic        reverse_bits;
    logic        cs_invert;
    logic        keep_cs;
    logic [15:0] cs_sel;
    logic [7:0]  prescale;
    res_t        due_results[$];
    int          errors;
    int          checked;
    int          n_starts;
    int          n_slots;
    int          n_idle;
    int          n_captured;
    int          n_done;

    function new();
      active       = 1'b0;
      slots_left   = '0;
      tx_left      = '0;
      rx_left      = '0;
      reverse_bits = 1'b0;
      cs_invert    = 1'b0;
      keep_cs      = 1'b0;
      cs_sel       = '0;
      prescale     = '0;
      errors       = 0;
      checked      = 0;
      n_starts     = 0;
      n_slots      = 0;
      n_idle       = 0;
      n_captured   = 0;
      n_done       = 0;
    endfunction

    function logic [7:0] flip(logic [7:0] b);
      return {<<{b}};
    endfunction

    function res_t held_result();
      res_t r;
      r = '0;
      r.cs_line        = cs_sel;
      r.clock_prescale = prescale;
      return r;
    endfunction

    function void note_request(spi_req_t q);
      res_t r;
      res_t fin;
      if (q.req_type == REQ_START) begin
        n_starts++;
        reverse_bits = q.bit_reversed;
        cs_invert    = q.invert_cs;
        keep_cs      = q.skip_cs_deassert;
        prescale     = q.prescale_request;
        cs_sel       = q.cs_select;
        tx_left      = q.tx_len;
        rx_left      = q.rx_len;
        if (q.skip_tx) slots_left = {1'b0, q.tx_len} + {1'b0, q.rx_len};
        else slots_left = (q.tx_len >= q.rx_len) ? {1'b0, q.tx_len} : {1'b0, q.rx_len};
        r = held_result();
        r.cs_drive = !q.skip_cs_assert;
        r.cs_level = r.cs_drive ? q.invert_cs : 1'b0;
        if (slots_left != 0) begin
          active = 1'b1;
          r.last = 1'b1;
          due_results.push_back(r);
        end else begin
          active = 1'b0;
          due_results.push_back(r);
          fin = held_result();
          fin.cs_drive = !keep_cs;
          fin.cs_level = fin.cs_drive ? !cs_invert : 1'b0;
          fin.done_res = 1'b1;
          fin.last     = 1'b1;
          due_results.push_back(fin);
          n_done++;
        end
      end else if (!active) begin
        n_idle++;
        r = held_result();
        r.idle_error = 1'b1;
        r.last       = 1'b1;
        due_results.push_back(r);
      end else begin
        n_slots++;
        r = held_result();
        r.mosi_valid = 1'b1;
        r.last       = 1'b1;
        if (tx_left != 0) begin
          tx_left--;
          r.mosi_byte = reverse_bits ? flip(q.tx_byte) : q.tx_byte;
        end
        slots_left = slots_left - 17'd1;
        if (rx_left != 0 && slots_left < {1'b0, rx_left}) begin
          rx_left--;
          n_captured++;
          r.rx_valid = 1'b1;
          r.rx_byte  = reverse_bits ? flip(q.miso_byte) : q.miso_byte;
        end
        if (slots_left == 0) begin
          active     = 1'b0;
          n_done++;
          r.done_res = 1'b1;
          r.cs_drive = !keep_cs;
          r.cs_level = r.cs_drive ? !cs_invert : 1'b0;
        end
        due_results.push_back(r);
      end
    endfunction

    function bit field_ok(string name, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(res_t got);
      res_t e;
      bit   ok;
      checked++;
      if (due_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
        return;
      end
      e  = due_results.pop_front();
      ok = 1'b1;
      ok &= field_ok("mosi_valid", e.mosi_valid, got.mosi_valid);
      ok &= field_ok("mosi_byte", e.mosi_byte, got.mosi_byte);
      ok &= field_ok("rx_valid", e.rx_valid, got.rx_valid);
      ok &= field_ok("rx_byte", e.rx_byte, got.rx_byte);
      ok &= field_ok("cs_drive", e.cs_drive, got.cs_drive);
      ok &= field_ok("cs_level", e.cs_level, got.cs_level);
      ok &= field_ok("cs_line", e.cs_line, got.cs_line);
      ok &= field_ok("clock_prescale", e.clock_prescale, got.clock_prescale);
      ok &= field_ok("done_res", e.done_res, got.done_res);
      ok &= field_ok("idle_error", e.idle_error, got.idle_error);
      ok &= field_ok("last", e.last, got.last);
      if (!ok) errors++;
    endfunction

    function void flag_leftovers();
      if (due_results.size() != 0) begin
        $error("%0d results never arrived", due_results.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  spi_ts_req_if req();
  spi_ts_rsp_if rsp();

  spi_transaction_sequencer dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  seq_scoreboard sb = new();
  int            burst_left;
  int            sent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic spi_req_t noise_req(logic kind);
    spi_req_t q;
    q.req_type         = kind;
    q.tx_len           = 16'($urandom);
    q.rx_len           = 16'($urandom);
    q.skip_tx          = 1'($urandom);
    q.bit_reversed     = 1'($urandom);
    q.invert_cs        = 1'($urandom);
    q.skip_cs_assert   = 1'($urandom);
    q.skip_cs_deassert = 1'($urandom);
    q.prescale_request = 8'($urandom);
    q.cs_select        = 16'($urandom);
    q.tx_byte          = 8'($urandom);
    q.miso_byte        = 8'($urandom);
    return q;
  endfunction

  function automatic int slot_count(logic [15:0] tl, logic [15:0] rl, logic skip);
    if (skip) return int'(tl) + int'(rl);
    return (tl >= rl) ? int'(tl) : int'(rl);
  endfunction

  task automatic send_req(spi_req_t q);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 3) ? 0 :
                   ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(1, 4);
      burst_left = $urandom_range(1, 30);
      repeat (gap) begin
        @(negedge clk);
        req.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    req.valid            <= 1'b1;
    req.req_type         <= q.req_type;
    req.tx_len           <= q.tx_len;
    req.rx_len           <= q.rx_len;
    req.skip_tx          <= q.skip_tx;
    req.bit_reversed     <= q.bit_reversed;
    req.invert_cs        <= q.invert_cs;
    req.skip_cs_assert   <= q.skip_cs_assert;
    req.skip_cs_deassert <= q.skip_cs_deassert;
    req.prescale_request <= q.prescale_request;
    req.cs_select        <= q.cs_select;
    req.tx_byte          <= q.tx_byte;
    req.miso_byte        <= q.miso_byte;
    do @(posedge clk); while (!req.ready);
    sb.note_request(q);
    sent++;
  endtask

  task automatic start_txn(logic [15:0] tl, logic [15:0] rl, logic skip, logic rev,
                           logic inv, logic no_assert, logic no_deassert,
                           logic [7:0] pre, logic [15:0] cs);
    spi_req_t q;
    q                  = noise_req(REQ_START);
    q.tx_len           = tl;
    q.rx_len           = rl;
    q.skip_tx          = skip;
    q.bit_reversed     = rev;
    q.invert_cs        = inv;
    q.skip_cs_assert   = no_assert;
    q.skip_cs_deassert = no_deassert;
    q.prescale_request = pre;
    q.cs_select        = cs;
    send_req(q);
  endtask

  task automatic xchg_slot(logic [7:0] txb, logic [7:0] misob);
    spi_req_t q;
    q           = noise_req(REQ_XCHG);
    q.tx_byte   = txb;
    q.miso_byte = misob;
    send_req(q);
  endtask

  task automatic random_slots(int n);
    repeat (n) xchg_slot(8'($urandom), 8'($urandom));
  endtask

  // result side: stretches of always-ready, light stalls and heavy stalls
  initial begin
    int mode;
    int phase_left;
    rsp.ready  = 1'b0;
    mode       = 0;
    phase_left = 0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(32, 200);
      end else begin
        phase_left--;
      end
      case (mode)
        0: begin
          rsp.ready <= 1'b1;
        end
        1: begin
          rsp.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          rsp.ready <= ($urandom_range(0, 15) < 4);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.mosi_valid     = rsp.mosi_valid;
      got.mosi_byte      = rsp.mosi_byte;
      got.rx_valid       = rsp.rx_valid;
      got.rx_byte        = rsp.rx_byte;
      got.cs_drive       = rsp.cs_drive;
      got.cs_level       = rsp.cs_level;
      got.cs_line        = rsp.cs_line;
      got.clock_prescale = rsp.clock_prescale;
      got.done_res       = rsp.done_res;
      got.idle_error     = rsp.idle_error;
      got.last           = rsp.last;
      sb.check_result(got);
    end
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int         roll;
    int         target;
    logic [15:0] tl;
    logic [15:0] rl;
    logic        skip;
    rst                  = 1'b1;
    req.valid            = 1'b0;
    req.req_type         = REQ_START;
    req.tx_len           = '0;
    req.rx_len           = '0;
    req.skip_tx          = 1'b0;
    req.bit_reversed     = 1'b0;
    req.invert_cs        = 1'b0;
    req.skip_cs_assert   = 1'b0;
    req.skip_cs_deassert = 1'b0;
    req.prescale_request = '0;
    req.cs_select        = '0;
    req.tx_byte          = '0;
    req.miso_byte        = '0;
    burst_left           = 0;
    sent                 = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle exchange, overlap and skip-transmit modes, zero-slot starts,
    // full-length starts cut short by a new start
    xchg_slot(8'hA5, 8'h5A);
    start_txn(16'd2, 16'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'hFF, 16'hFFFF);
    xchg_slot(8'h01, 8'hFF);
    xchg_slot(8'h80, 8'h00);
    start_txn(16'd1, 16'd2, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 16'h0000);
    xchg_slot(8'hFF, 8'h01);
    xchg_slot(8'h00, 8'h80);
    xchg_slot(8'h3C, 8'hC3);
    start_txn(16'd0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h12, 16'h0304);
    start_txn(16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h34, 16'h0102);
    start_txn(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h55, 16'hAA55);
    xchg_slot(8'hF0, 8'h0F);
    xchg_slot(8'h12, 8'h34);
    start_txn(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hAA, 16'h55AA);
    xchg_slot(8'h77, 8'h88);
    start_txn(16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h01, 16'h8001);
    xchg_slot(8'hC0, 8'h03);
    start_txn(16'd1, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h80, 16'h7FFE);
    xchg_slot(8'h96, 8'h69);
    xchg_slot(8'h11, 8'h22);

    target = sent + 1200;
    while (sent < target) begin
      roll = $urandom_range(0, 99);
      skip = 1'($urandom);
      if (roll < 72) begin
        tl = 16'($urandom_range(0, 6));
        rl = 16'($urandom_range(0, 6));
        start_txn(tl, rl, skip, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  8'($urandom), 16'($urandom));
        random_slots(slot_count(tl, rl, skip));
      end else if (roll < 82) begin
        tl = 16'($urandom_range(1, 12));
        rl = 16'($urandom_range(1, 12));
        start_txn(tl, rl, skip, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  8'($urandom), 16'($urandom));
        random_slots($urandom_range(0, slot_count(tl, rl, skip) - 1));
      end else if (roll < 90) begin
        tl = 16'($urandom);
        rl = 16'($urandom);
        start_txn(tl, rl, skip, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  8'($urandom), 16'($urandom));
        random_slots($urandom_range(0, 5));
      end else begin
        random_slots($urandom_range(1, 3));
      end
    end

    @(negedge clk);
    req.valid <= 1'b0;
    for (int w = 0; w < 5000 && sb.due_results.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.flag_leftovers();

    $display("Covered %0d requests: %0d starts, %0d exchange slots, %0d idle exchanges.",
             sent, sb.n_starts, sb.n_slots, sb.n_idle);
    $display("Checked %0d result transfers: %0d captured bytes, %0d completions.",
             sb.checked, sb.n_captured, sb.n_done);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: spi_transaction_sequencer.f
src/spi_ts_pkg.sv
src/spi_ts_if.sv
src/spi_ts_front.sv
src/spi_ts_fifo.sv
src/spi_ts_back.sv
src/spi_transaction_sequencer.sv
src/spi_ts_checker.sv
tb/sv/spi_transaction_sequencer_test.sv
